### hdl/maf_pkg.sv
`default_nettype none
package maf_pkg;

   localparam int MAX_WINDOW  = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int SUM_BITS    = 24;

   // Ring pointer, window, fill count and divider step counter widths.
   localparam int PTR_BITS = $clog2(MAX_WINDOW);
   localparam int WIN_BITS = PTR_BITS + 1;
   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   // Configuration port layout.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_INDEX_BITS = CSR_ADDR_BITS - 2;
   localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = '0;
   localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(1);

   localparam logic [WIN_BITS-1:0] WINDOW_MAX = WIN_BITS'(MAX_WINDOW);
   localparam logic [SUM_BITS-1:0] SAT_POS_MAG = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [SUM_BITS-1:0] SAT_NEG_MAG = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] SAT_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAT_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

endpackage
`default_nettype wire

### hdl/moving_average_filter.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_sample (s16), req_block_start
// rsp       out        rsp_valid / rsp_stall   rsp_average (s16)
// csr       in         APB psel/penable/pwrite window_length at byte address 0
//
// Each request passes through these steps before the next is accepted: accept
// and read the ring, update the running sum, set up the divider, run the
// shared restoring divider (one quotient bit a cycle), then saturate and load
// the output register.
// Reset is synchronous and clears the sum, the ring position, the fill count
// and the window register (to one); the sample ring itself is not cleared.
// req_stall is low only while the sequencer idles. A result waiting under
// rsp_stall does not block the next request; only a second result would wait.
module moving_average_filter (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire  signed [maf_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  wire                                         req_block_start,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic signed [maf_pkg::SAMPLE_BITS-1:0]      rsp_average,
   input  wire                                         csr_psel,
   input  wire                                         csr_penable,
   input  wire                                         csr_pwrite,
   input  wire         [maf_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire         [maf_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic        [maf_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                        csr_pready
);

   localparam int PB = maf_pkg::PTR_BITS;
   localparam int WB = maf_pkg::WIN_BITS;
   localparam int SB = maf_pkg::SUM_BITS;
   localparam int XB = maf_pkg::SAMPLE_BITS;
   localparam int CB = maf_pkg::STEP_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [WB-1:0]        window_ff, window_in;
   logic signed [SB-1:0] sum_ff, sum_in;
   logic [PB-1:0]        wpos_ff, wpos_in;
   logic [WB-1:0]        fill_ff, fill_in;
   logic signed [XB-1:0] sample_ff, sample_in;
   logic                 sub_ff, sub_in;
   logic [SB-1:0]        num_ff, num_in;
   logic [PB-1:0]        rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [CB-1:0]        step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [XB-1:0]        rsp_average_ff, rsp_average_in;

   // Sample ring; read data is registered.
   logic signed [XB-1:0] ring [maf_pkg::MAX_WINDOW];
   logic signed [XB-1:0] ring_rd_ff;

   logic [WB-1:0] win_eff;
   logic          accept;
   logic          csr_write;
   logic [PB-1:0] old_addr;
   logic [WB-1:0] fill_base;
   logic [WB:0]   trial;
   logic          trial_ge;
   logic [WB:0]   trial_diff;

   // Window of zero acts as one, anything above the ring depth as the depth.
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WB'(1);
      end else if (window_ff > maf_pkg::WINDOW_MAX) begin
         win_eff = maf_pkg::WINDOW_MAX;
      end else begin
         win_eff = window_ff;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // The sample that leaves the window sits win_eff places behind the write
   // pointer. With a full-depth window that is the slot about to be rewritten,
   // which is why the ring is read at acceptance, before the write in the sum update.
   assign old_addr  = wpos_ff - win_eff[PB-1:0];
   assign fill_base = req_block_start ? '0 : fill_ff;

   // One restoring step: shift in the next dividend bit and try the divisor.
   assign trial      = {1'b0, rem_ff, num_ff[SB-1]};
   assign trial_ge   = trial >= {1'b0, win_eff};
   assign trial_diff = trial - {1'b0, win_eff};

   always_comb begin
      state_in       = state_ff;
      window_in      = window_ff;
      sum_in         = sum_ff;
      wpos_in        = wpos_ff;
      fill_in        = fill_ff;
      sample_in      = sample_ff;
      sub_in         = sub_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      neg_in         = neg_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write && csr_paddr[maf_pkg::CSR_ADDR_BITS-1:2] == maf_pkg::REG_WINDOW_LENGTH) begin
         window_in = csr_pwdata[WB-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               sub_in    = fill_base >= win_eff;
               if (req_block_start) begin
                  sum_in = '0;
               end
               fill_in  = (fill_base < maf_pkg::WINDOW_MAX) ? fill_base + WB'(1) : fill_base;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The sum wraps in its own width by design.
            sum_in = sum_ff + SB'(sample_ff) - (sub_ff ? SB'(ring_rd_ff) : '0);
            wpos_in  = wpos_ff + PB'(1);
            state_in = ST_INIT;
         end
         ST_INIT: begin
            neg_in   = sum_ff[SB-1];
            num_in   = sum_ff[SB-1] ? SB'(-sum_ff) : sum_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[PB-1:0] : trial[PB-1:0];
            num_in  = {num_ff[SB-2:0], trial_ge};
            step_in = step_ff + CB'(1);
            if (step_ff == CB'(SB - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait only if an earlier result is still held and not taken now.
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_average_in = (num_ff > maf_pkg::SAT_NEG_MAG) ? maf_pkg::SAT_NEG
                                                                  : XB'(-num_ff);
               end else begin
                  rsp_average_in = (num_ff > maf_pkg::SAT_POS_MAG) ? maf_pkg::SAT_POS
                                                                  : num_ff[XB-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= maf_pkg::WINDOW_RESET;
         sum_ff       <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      sub_ff         <= sub_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      neg_ff         <= neg_in;
      step_ff        <= step_in;
      rsp_average_ff <= rsp_average_in;
   end

   // Ring read at acceptance, ring write in the sum update state that follows.
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         ring[wpos_ff] <= sample_ff;
      end
      ring_rd_ff <= ring[old_addr];
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[maf_pkg::CSR_ADDR_BITS-1:2] == maf_pkg::REG_WINDOW_LENGTH)
                        ? maf_pkg::CSR_DATA_BITS'(window_ff) : '0;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("accepted request did not start the sum update");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> {1'b0, rem_ff} < win_eff)
      else $error("divider remainder not below the window");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> step_ff < CB'(SB))
      else $error("divider ran past the last quotient bit");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= maf_pkg::WINDOW_MAX)
      else $error("fill count above ring depth");
`endif

endmodule
`default_nettype wire
